// File: src/hsvt_pkg.sv
// ----------------------------------------------------------------------------
// hsvt_pkg
// Shared types and constants of the HSV threshold mask pipeline.
// ----------------------------------------------------------------------------
package hsvt_pkg;

	localparam int PIX_W     = 8;   // channel, hue, saturation width
	localparam int NUM_W     = 17;  // divider numerator width
	localparam int RCP_W     = 18;  // reciprocal table entry width
	localparam int RCP_SHIFT = 18;  // reciprocal scale: 2^18 / (2*x)
	localparam int CFG_IDX_W = 3;

	localparam logic [PIX_W-1:0] HUE_WRAP = 8'd180;

	// Register reset values
	localparam logic [PIX_W-1:0] HUE_MIN_RST = 8'd64;
	localparam logic [PIX_W-1:0] HUE_MAX_RST = 8'd129;
	localparam logic [PIX_W-1:0] SAT_MIN_RST = 8'd24;
	localparam logic [PIX_W-1:0] SAT_MAX_RST = 8'd255;
	localparam logic [PIX_W-1:0] VAL_MIN_RST = 8'd109;
	localparam logic [PIX_W-1:0] VAL_MAX_RST = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUE_MIN = 3'd0,
		CFG_HUE_MAX = 3'd1,
		CFG_SAT_MIN = 3'd2,
		CFG_SAT_MAX = 3'd3,
		CFG_VAL_MIN = 3'd4,
		CFG_VAL_MAX = 3'd5
	} cfg_idx_t;

	// Largest channel; red wins ties over green, green over blue
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [PIX_W-1:0] hue_min;
		logic [PIX_W-1:0] hue_max;
		logic [PIX_W-1:0] sat_min;
		logic [PIX_W-1:0] sat_max;
		logic [PIX_W-1:0] val_min;
		logic [PIX_W-1:0] val_max;
	} cfg_t;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} en_t;

endpackage

// File: src/hsvt_front.sv
// ----------------------------------------------------------------------------
// hsvt_front
// Stages 1 and 2: channel max/min, hue sector, and the numerators of the
// saturation and hue divisions.
// ----------------------------------------------------------------------------
module hsvt_front (
	input  logic                        clk,
	input  hsvt_pkg::en_t               en,
	input  logic [hsvt_pkg::PIX_W-1:0]  blue,
	input  logic [hsvt_pkg::PIX_W-1:0]  green,
	input  logic [hsvt_pkg::PIX_W-1:0]  red,
	output logic [hsvt_pkg::NUM_W-1:0]  sat_num,
	output logic [hsvt_pkg::NUM_W-1:0]  hue_num,
	output logic [hsvt_pkg::PIX_W-1:0]  vmax,
	output logic [hsvt_pkg::PIX_W-1:0]  delta
);
	import hsvt_pkg::*;

	logic [PIX_W-1:0]        vmax_c, vmin_c;
	sector_t                 sect_c;
	logic signed [PIX_W:0]   diff_c;

	logic [PIX_W-1:0]        vmax_s1, d_s1;
	sector_t                 sect_s1;
	logic signed [PIX_W:0]   diff_s1;

	logic signed [17:0]      diff_x, d_x, diff30, offs, t_sum, t_pos;
	logic [NUM_W-1:0]        hnum_c, snum_c;

	logic [NUM_W-1:0]        snum_s2, hnum_s2;
	logic [PIX_W-1:0]        vmax_s2, d_s2;

	// Pick the largest channel and the difference that sets the hue
	always_comb begin
		if (red >= green && red >= blue) begin
			sect_c = SECT_RED;
			vmax_c = red;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sect_c = SECT_GREEN;
			vmax_c = green;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sect_c = SECT_BLUE;
			vmax_c = blue;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		vmin_c = red;
		if (green < vmin_c) vmin_c = green;
		if (blue < vmin_c) vmin_c = blue;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			vmax_s1 <= vmax_c;
			d_s1    <= vmax_c - vmin_c;
			sect_s1 <= sect_c;
			diff_s1 <= diff_c;
		end
	end

	// Build the doubled hue numerator 2t+d and the saturation numerator 510d+v
	always_comb begin
		diff_x = 18'(diff_s1);
		d_x    = $signed({10'b0, d_s1});
		diff30 = diff_x * 18'sd30;
		case (sect_s1)
			SECT_RED:   offs = '0;
			SECT_GREEN: offs = d_x * 18'sd60;
			SECT_BLUE:  offs = d_x * 18'sd120;
			default:    offs = '0;
		endcase
		t_sum = diff30 + offs;
		t_pos = (t_sum < 0) ? t_sum + d_x * 18'sd180 : t_sum;
		hnum_c = NUM_W'({t_pos[15:0], 1'b0}) + NUM_W'(d_s1);
		snum_c = NUM_W'(d_s1) * NUM_W'(510) + NUM_W'(vmax_s1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			snum_s2 <= snum_c;
			hnum_s2 <= hnum_c;
			vmax_s2 <= vmax_s1;
			d_s2    <= d_s1;
		end
	end

	assign sat_num = snum_s2;
	assign hue_num = hnum_s2;
	assign vmax    = vmax_s2;
	assign delta   = d_s2;

endmodule

// File: src/hsvt_divider.sv
// ----------------------------------------------------------------------------
// hsvt_divider
// Stages 3 to 5: quotient num / (2*den) by reciprocal table, multiply, and
// one upward correction step. The quotient must fit in eight bits.
// ----------------------------------------------------------------------------
module hsvt_divider (
	input  logic                        clk,
	input  hsvt_pkg::en_t               en,
	input  logic [hsvt_pkg::NUM_W-1:0]  num,
	input  logic [hsvt_pkg::PIX_W-1:0]  den,
	output logic [hsvt_pkg::PIX_W-1:0]  quot
);
	import hsvt_pkg::*;

	localparam int RcpNum = 1 << (RCP_SHIFT - 1);

	logic [RCP_W-1:0]           rcp_tbl [2**PIX_W];
	logic [NUM_W+RCP_W-1:0]     prod;

	logic [PIX_W-1:0]           q_s3, q_s4, q_s5;
	logic [NUM_W-1:0]           n_s3, n_s4;
	logic [PIX_W-1:0]           x_s3;
	logic [2*PIX_W+1:0]         p_s4;

	// Reciprocal table: floor(2^17 / x); entry zero holds zero
	assign rcp_tbl[0] = '0;
	for (genvar i = 1; i < 2**PIX_W; i++) begin : g_rcp
		localparam logic [RCP_W-1:0] RcpVal = RCP_W'(RcpNum / i);
		assign rcp_tbl[i] = RcpVal;
	end

	// Estimate the quotient; it is exact or one low
	assign prod = NUM_W'(num) * rcp_tbl[den];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q_s3 <= prod[RCP_SHIFT +: PIX_W];
			n_s3 <= num;
			x_s3 <= den;
		end
	end

	// Form the product of the next quotient candidate and the divisor
	always_ff @(posedge clk) begin
		if (en.s4) begin
			p_s4 <= ({1'b0, q_s3} + (PIX_W+1)'(1)) * {x_s3, 1'b0};
			q_s4 <= q_s3;
			n_s4 <= n_s3;
		end
	end

	// Step up when the candidate still fits under the numerator
	always_ff @(posedge clk) begin
		if (en.s5) begin
			q_s5 <= (p_s4 <= (2*PIX_W+2)'(n_s4)) ? PIX_W'(q_s4 + 1'b1) : q_s4;
		end
	end

	assign quot = q_s5;

endmodule

// File: src/hsvt_window.sv
// ----------------------------------------------------------------------------
// hsvt_window
// Stage 6: final hue and saturation fix-up and the H/S/V window test.
// ----------------------------------------------------------------------------
module hsvt_window (
	input  logic                        clk,
	input  hsvt_pkg::en_t               en,
	input  hsvt_pkg::cfg_t              cfg,
	input  logic [hsvt_pkg::PIX_W-1:0]  hue_q,
	input  logic [hsvt_pkg::PIX_W-1:0]  sat_q,
	input  logic [hsvt_pkg::PIX_W-1:0]  vmax,
	input  logic                        d_zero,
	output logic                        hit
);
	import hsvt_pkg::*;

	logic [PIX_W-1:0] hue, sat;
	logic             hue_ok, sat_ok, val_ok;
	logic             hit_s6;

	// Zero the hue for gray pixels and wrap 180 to 0; zero S for black; then test H, S and V against their windows
	always_comb begin
		if (d_zero || hue_q == HUE_WRAP) hue = '0;
		else hue = hue_q;
		sat = (vmax == '0) ? '0 : sat_q;
		if (cfg.hue_min > cfg.hue_max) hue_ok = (hue >= cfg.hue_min) || (hue <= cfg.hue_max);
		else hue_ok = (hue >= cfg.hue_min) && (hue <= cfg.hue_max);
		sat_ok = (sat >= cfg.sat_min) && (sat <= cfg.sat_max);
		val_ok = (vmax >= cfg.val_min) && (vmax <= cfg.val_max);
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			hit_s6 <= hue_ok && sat_ok && val_ok;
		end
	end

	assign hit = hit_s6;

endmodule

// File: src/hsv_threshold_mask.sv
// ----------------------------------------------------------------------------
// hsv_threshold_mask
// Per-pixel HSV color window test on a BGR pixel stream.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock while the output is not stalled and
// returns one mask bit per pixel, in order. The mask bit is computed in a
// six-stage pipeline: channel max/min, numerator build, reciprocal multiply,
// correction product, quotient fix, window compare. Each stage holds its
// item while the next is full, so an empty stage is filled even while the
// output waits. Configuration writes are taken in any cycle and act on
// pixels that reach the window stage.
module hsv_threshold_mask (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] in_range, [7:1] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [hsvt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hsvt_pkg::PIX_W-1:0]     cfg_data
);
	import hsvt_pkg::*;

	cfg_t             cfg_q;
	en_t              en;
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [NUM_W-1:0] sat_num, hue_num;
	logic [PIX_W-1:0] vmax, delta;
	logic [PIX_W-1:0] sat_q, hue_q;
	logic [PIX_W-1:0] v_s3, v_s4, v_s5;
	logic             dz_s3, dz_s4, dz_s5;
	logic             hit;

	// Register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_min <= HUE_MIN_RST;
			cfg_q.hue_max <= HUE_MAX_RST;
			cfg_q.sat_min <= SAT_MIN_RST;
			cfg_q.sat_max <= SAT_MAX_RST;
			cfg_q.val_min <= VAL_MIN_RST;
			cfg_q.val_max <= VAL_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HUE_MIN: cfg_q.hue_min <= cfg_data;
				CFG_HUE_MAX: cfg_q.hue_max <= cfg_data;
				CFG_SAT_MIN: cfg_q.sat_min <= cfg_data;
				CFG_SAT_MAX: cfg_q.sat_max <= cfg_data;
				CFG_VAL_MIN: cfg_q.val_min <= cfg_data;
				CFG_VAL_MAX: cfg_q.val_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en.s6 = !vld_s6 || m_axis_tready;
		en.s5 = !vld_s5 || en.s6;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	assign s_axis_tready = en.s1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= s_axis_tvalid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
			if (en.s6) vld_s6 <= vld_s5;
		end
	end

	hsvt_front u_front (
		.clk     (clk),
		.en      (en),
		.blue    (s_axis_tdata[7:0]),
		.green   (s_axis_tdata[15:8]),
		.red     (s_axis_tdata[23:16]),
		.sat_num (sat_num),
		.hue_num (hue_num),
		.vmax    (vmax),
		.delta   (delta)
	);

	hsvt_divider u_sat_div (
		.clk  (clk),
		.en   (en),
		.num  (sat_num),
		.den  (vmax),
		.quot (sat_q)
	);

	hsvt_divider u_hue_div (
		.clk  (clk),
		.en   (en),
		.num  (hue_num),
		.den  (delta),
		.quot (hue_q)
	);

	// Carry V and the gray flag alongside the dividers
	always_ff @(posedge clk) begin
		if (en.s3) begin
			v_s3  <= vmax;
			dz_s3 <= (delta == '0);
		end
		if (en.s4) begin
			v_s4  <= v_s3;
			dz_s4 <= dz_s3;
		end
		if (en.s5) begin
			v_s5  <= v_s4;
			dz_s5 <= dz_s4;
		end
	end

	hsvt_window u_window (
		.clk    (clk),
		.en     (en),
		.cfg    (cfg_q),
		.hue_q  (hue_q),
		.sat_q  (sat_q),
		.vmax   (v_s5),
		.d_zero (dz_s5),
		.hit    (hit)
	);

	assign m_axis_tvalid = vld_s6;
	assign m_axis_tdata  = {7'b0, hit};

	// A draining output never holds off the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input held off while output drains");

	// A full pipeline with a stalled output takes nothing
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tready && vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6)
		|-> !s_axis_tready)
		else $error("input taken into a full stalled pipeline");

	// Without an output transfer no item leaves the pipeline
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && m_axis_tready) |=>
		$countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6}) >=
		$past($countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6})))
		else $error("item lost inside the pipeline");

endmodule
